// File: hdl/cps_pkg.sv
// Shared types and codes for the convex polygon slab point test unit.
`timescale 1ns / 1ps

package cps_pkg;

   // Width of a vertex index field in a transaction
   localparam int VIDX_W = 6;

   typedef enum logic [1:0] {
      CMD_ADD_VERTEX = 2'd0,
      CMD_ADD_EDGE   = 2'd1,
      CMD_BUILD      = 2'd2,
      CMD_QUERY      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_CONFLICT  = 2'd2,
      ST_NOT_BUILT = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_ADD_V, S_ADD_E,
      S_Q_START, S_Q_PROBE, S_Q_CHECK,
      S_E_EDGE, S_E_V0, S_E_V1, S_E_V2,
      S_E_MUL1, S_E_WAIT1, S_E_MUL2, S_E_WAIT2, S_E_SIGN,
      S_B_INIT, S_B_PASS, S_B_SCAN, S_B_PASS_END,
      S_B_E_RD, S_B_E_A, S_B_E_B, S_B_E_C,
      S_B_S_RD, S_B_S_CHK, S_B_T_A, S_B_T_B, S_B_T_C
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_ADD_V, OP_ADD_E,
      OP_Q_START, OP_Q_PROBE, OP_Q_CHECK,
      OP_E_EDGE, OP_E_V0, OP_E_V1, OP_E_V2,
      OP_E_MUL1, OP_E_MUL2, OP_E_WAIT, OP_E_SIGN,
      OP_B_INIT, OP_B_PASS, OP_B_SCAN, OP_B_PASS_END,
      OP_B_E_RD, OP_B_E_A, OP_B_E_B, OP_B_E_C,
      OP_B_S_RD, OP_B_S_CHK, OP_B_T_A, OP_B_T_B, OP_B_T_C
   } op_type;

   // Controller to datapath
   typedef struct packed {
      op_type     op;
      logic       reply;
      logic       reply_inside;
      status_type reply_status;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    v_full;
      logic    e_full;
      logic    built;
      logic    in_box;
      logic    search_empty;
      logic    x_below;
      logic    x_above;
      logic    has_both;
      logic    scan_done;
      logic    best_valid;
      logic    edges_done;
      logic    edge_bad;
      logic    slabs_done;
      logic    spans;
      logic    has_top;
      logic    top_above;
      logic    top_below;
      logic    mac_busy;
      logic    sign_ok;
      logic    eval_bottom;
   } dp_status_type;

endpackage

// File: hdl/cps_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module cps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cps_mac.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
`timescale 1ns / 1ps

module cps_mac #(
   parameter int OW = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 clear,
   input  logic                 sub,
   input  logic signed [OW-1:0] op_a,
   input  logic signed [OW-1:0] op_b,
   output logic                 busy,
   output logic signed [2*OW:0] acc
);

   localparam int CNTW = $clog2(OW + 1);

   logic [2*OW-1:0]      mcand_ff, mcand_in;
   logic [OW-1:0]        mplier_ff, mplier_in;
   logic                 neg_ff, neg_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic signed [2*OW:0] acc_ff, acc_in;
   logic [OW-1:0]        mag_a, mag_b;
   logic signed [2*OW:0] part;

   // Magnitudes of the operands
   assign mag_a = op_a[OW-1] ? (~unsigned'(op_a) + 1'b1) : unsigned'(op_a);
   assign mag_b = op_b[OW-1] ? (~unsigned'(op_b) + 1'b1) : unsigned'(op_b);
   assign part  = signed'({1'b0, mcand_ff});

   // Load operands, then add or subtract one shifted partial product a cycle
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      if (load) begin
         mcand_in  = {{OW{1'b0}}, mag_a};
         mplier_in = mag_b;
         neg_in    = op_a[OW-1] ^ op_b[OW-1] ^ sub;
         cnt_in    = CNTW'(OW);
         if (clear) begin
            acc_in = '0;
         end
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_in = neg_ff ? (acc_ff - part) : (acc_ff + part);
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
   end

   assign busy = (cnt_ff != '0);
   assign acc  = acc_ff;

endmodule

// File: hdl/cps_datapath.sv
// Datapath: vertex, edge and slab stores, counters, bounding box, search and edge test.
`timescale 1ns / 1ps

module cps_datapath import cps_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 64,
   parameter int COORD_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  cmd,
   output dp_status_type                 status,
   input  logic [1:0]                    req_cmd,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic [VIDX_W-1:0]             req_first_vertex,
   input  logic [VIDX_W-1:0]             req_second_vertex,
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   output logic [VIDX_W-1:0]             rsp_new_index,
   output logic [1:0]                    rsp_status
);

   localparam int CW   = COORD_WIDTH;
   localparam int VAW  = $clog2(MAX_VERTICES);
   localparam int EAW  = $clog2(MAX_EDGES);
   localparam int VCW  = $clog2(MAX_VERTICES + 1);
   localparam int ECW  = $clog2(MAX_EDGES + 1);
   localparam int CMPW = (VCW > VIDX_W) ? VCW : VIDX_W;
   localparam int SW   = VAW + 2;
   localparam int OW   = CW + 2;
   localparam int SEW  = 2 * EAW + 2;
   localparam logic signed [SW-1:0] ONE_S = SW'(1);
   localparam logic signed [CW-1:0] BIG   = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] SMALL = {1'b1, {(CW-1){1'b0}}};

   op_type op;
   assign op = cmd.op;

   // Registers
   cmd_type              cmd_ff, cmd_in;
   logic signed [CW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [VIDX_W-1:0]    fv_ff, fv_in, sv_ff, sv_in;
   logic [VCW-1:0]       vcount_ff, vcount_in;
   logic [ECW-1:0]       ecount_ff, ecount_in;
   logic [VAW-1:0]       scount_ff, scount_in;
   logic signed [CW-1:0] minx_ff, minx_in, miny_ff, miny_in;
   logic signed [CW-1:0] maxx_ff, maxx_in, maxy_ff, maxy_in;
   logic                 built_ff, built_in;
   logic [VCW-1:0]       idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic signed [CW-1:0] prev_ff, prev_in, best_ff, best_in;
   logic                 prev_valid_ff, prev_valid_in, best_valid_ff, best_valid_in;
   logic [ECW-1:0]       e_ff, e_in;
   logic [VIDX_W-1:0]    eb_ff, eb_in;
   logic signed [CW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [CW-1:0] left_ff, left_in, right_ff, right_in;
   logic signed [CW-1:0] ymax_ff, ymax_in, ymin_ff, ymin_in;
   logic [VAW-1:0]       i_ff, i_in;
   logic [EAW-1:0]       cur_top_ff, cur_top_in;
   logic signed [SW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [VAW-1:0]       mid_ff, mid_in;
   logic [EAW-1:0]       q_top_ff, q_top_in, q_bot_ff, q_bot_in;
   logic                 eval_bot_ff, eval_bot_in;
   logic signed [OW-1:0] t_ff, t_in, d_ff, d_in, dy_ff, dy_in, ey_ff, ey_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_inside_ff, rsp_inside_in;
   logic [VIDX_W-1:0]    rsp_index_ff, rsp_index_in;
   status_type           rsp_status_ff, rsp_status_in;

   // Memory ports
   logic [CW-1:0]         vx_rd, vy_rd;
   logic [VAW-1:0]        v_rd_addr;
   logic                  v_we;
   logic [2*VIDX_W-1:0]   ed_rd;
   logic [EAW-1:0]        ed_rd_addr;
   logic                  ed_we;
   logic [2*CW-1:0]       bnd_rd;
   logic                  bnd_we;
   logic [VAW-1:0]        slab_rd_addr, sed_wr_addr;
   logic [SEW-1:0]        sed_rd, sed_wr_data;
   logic                  sed_we;

   // Decoded read data and helpers
   logic signed [CW-1:0]  vx_s, vy_s, b0, b1;
   logic [VIDX_W-1:0]     ed_a, ed_b;
   logic                  sed_ht, sed_hb;
   logic [EAW-1:0]        sed_top, sed_bot;
   logic signed [SW:0]    sum_lh;
   logic [VAW-1:0]        mid_calc;
   logic signed [CW-1:0]  tmax, tmin;
   logic signed [CW:0]    dxe, txe, dye, eye;
   logic                  mac_load, mac_busy;
   logic signed [2*OW:0]  acc;
   logic                  v_full, e_full, spans, top_above, top_below;
   logic                  acc_neg, acc_zero;

   assign vx_s    = signed'(vx_rd);
   assign vy_s    = signed'(vy_rd);
   assign b0      = signed'(bnd_rd[CW-1:0]);
   assign b1      = signed'(bnd_rd[2*CW-1:CW]);
   assign ed_a    = ed_rd[2*VIDX_W-1:VIDX_W];
   assign ed_b    = ed_rd[VIDX_W-1:0];
   assign sed_ht  = sed_rd[SEW-1];
   assign sed_hb  = sed_rd[SEW-2];
   assign sed_top = sed_rd[2*EAW-1:EAW];
   assign sed_bot = sed_rd[EAW-1:0];

   assign v_full   = (vcount_ff >= VCW'(MAX_VERTICES));
   assign e_full   = (ecount_ff >= ECW'(MAX_EDGES));
   assign sum_lh   = (SW+1)'(lo_ff) + (SW+1)'(hi_ff);
   assign mid_calc = sum_lh[VAW:1];
   assign spans    = (left_ff <= b0) && (right_ff >= b1);
   assign tmax     = (ay_ff > vy_s) ? ay_ff : vy_s;
   assign tmin     = (ay_ff < vy_s) ? ay_ff : vy_s;
   assign top_above = (tmax >= ymax_ff) && (tmin >= ymin_ff);
   assign top_below = (tmax <= ymax_ff) && (tmin <= ymin_ff);
   assign dxe      = (CW+1)'(vx_s) - (CW+1)'(ax_ff);
   assign txe      = (CW+1)'(qx_ff) - (CW+1)'(ax_ff);
   assign dye      = (CW+1)'(vy_s) - (CW+1)'(ay_ff);
   assign eye      = (CW+1)'(qy_ff) - (CW+1)'(ay_ff);
   assign acc_neg  = acc[2*OW];
   assign acc_zero = (acc == '0);

   // Memory address and write selection
   always_comb begin
      case (op)
         OP_B_E_A, OP_B_T_A, OP_E_V0: v_rd_addr = VAW'(ed_a);
         OP_B_E_B, OP_B_T_B, OP_E_V1: v_rd_addr = VAW'(eb_ff);
         default:                     v_rd_addr = VAW'(idx_ff);
      endcase
      case (op)
         OP_B_S_CHK: ed_rd_addr = sed_top;
         OP_E_EDGE:  ed_rd_addr = eval_bot_ff ? q_bot_ff : q_top_ff;
         default:    ed_rd_addr = EAW'(e_ff);
      endcase
      slab_rd_addr = (op == OP_Q_PROBE) ? mid_calc : i_ff;
      v_we   = (op == OP_ADD_V) && !v_full;
      ed_we  = (op == OP_ADD_E) && !e_full;
      bnd_we = (op == OP_B_PASS_END) && best_valid_ff && prev_valid_ff;
      sed_we = 1'b0;
      sed_wr_addr = i_ff;
      sed_wr_data = '0;
      case (op)
         OP_B_PASS_END: begin
            sed_we      = best_valid_ff && prev_valid_ff;
            sed_wr_addr = scount_ff;
         end
         OP_B_S_CHK: begin
            sed_we      = spans && !sed_ht;
            sed_wr_data = {1'b1, sed_hb, EAW'(e_ff), sed_bot};
         end
         OP_B_T_C: begin
            sed_we = top_above || top_below;
            if (top_above) begin
               sed_wr_data = {2'b11, cur_top_ff, EAW'(e_ff)};
            end else begin
               sed_wr_data = {2'b11, EAW'(e_ff), cur_top_ff};
            end
         end
         default: sed_we = 1'b0;
      endcase
   end

   cps_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_vx_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(VAW'(vcount_ff)), .wr_data(unsigned'(qx_ff)),
      .rd_addr(v_rd_addr), .rd_data(vx_rd)
   );

   cps_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_vy_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(VAW'(vcount_ff)), .wr_data(unsigned'(qy_ff)),
      .rd_addr(v_rd_addr), .rd_data(vy_rd)
   );

   cps_ram #(.WIDTH(2*VIDX_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(ed_we), .wr_addr(EAW'(ecount_ff)), .wr_data({fv_ff, sv_ff}),
      .rd_addr(ed_rd_addr), .rd_data(ed_rd)
   );

   cps_ram #(.WIDTH(2*CW), .DEPTH(MAX_VERTICES)) u_bound_ram (
      .clock(clock), .wr_en(bnd_we), .wr_addr(scount_ff),
      .wr_data({unsigned'(best_ff), unsigned'(prev_ff)}),
      .rd_addr(slab_rd_addr), .rd_data(bnd_rd)
   );

   cps_ram #(.WIDTH(SEW), .DEPTH(MAX_VERTICES)) u_slab_edge_ram (
      .clock(clock), .wr_en(sed_we), .wr_addr(sed_wr_addr), .wr_data(sed_wr_data),
      .rd_addr(slab_rd_addr), .rd_data(sed_rd)
   );

   // Shared multiply-accumulate for the edge height test
   assign mac_load = (op == OP_E_MUL1) || (op == OP_E_MUL2);

   cps_mac #(.OW(OW)) u_mac (
      .clock(clock), .reset(reset), .load(mac_load), .clear(op == OP_E_MUL1),
      .sub(op == OP_E_MUL2),
      .op_a((op == OP_E_MUL1) ? t_ff : ey_ff),
      .op_b((op == OP_E_MUL1) ? dy_ff : d_ff),
      .busy(mac_busy), .acc(acc)
   );

   // Next register values per command
   always_comb begin
      cmd_in = cmd_ff;  qx_in = qx_ff;  qy_in = qy_ff;  fv_in = fv_ff;  sv_in = sv_ff;
      vcount_in = vcount_ff;  ecount_in = ecount_ff;  scount_in = scount_ff;
      minx_in = minx_ff;  miny_in = miny_ff;  maxx_in = maxx_ff;  maxy_in = maxy_ff;
      built_in = built_ff;  idx_in = idx_ff;  pend_in = pend_ff;
      prev_in = prev_ff;  prev_valid_in = prev_valid_ff;
      best_in = best_ff;  best_valid_in = best_valid_ff;
      e_in = e_ff;  eb_in = eb_ff;  ax_in = ax_ff;  ay_in = ay_ff;
      left_in = left_ff;  right_in = right_ff;  ymax_in = ymax_ff;  ymin_in = ymin_ff;
      i_in = i_ff;  cur_top_in = cur_top_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  mid_in = mid_ff;
      q_top_in = q_top_ff;  q_bot_in = q_bot_ff;  eval_bot_in = eval_bot_ff;
      t_in = t_ff;  d_in = d_ff;  dy_in = dy_ff;  ey_in = ey_ff;

      case (op)
         OP_ACCEPT: begin
            cmd_in = cmd_type'(req_cmd);
            qx_in  = req_coord_x;
            qy_in  = req_coord_y;
            fv_in  = req_first_vertex;
            sv_in  = req_second_vertex;
         end
         OP_ADD_V: begin
            if (!v_full) begin
               minx_in   = (qx_ff < minx_ff) ? qx_ff : minx_ff;
               miny_in   = (qy_ff < miny_ff) ? qy_ff : miny_ff;
               maxx_in   = (qx_ff > maxx_ff) ? qx_ff : maxx_ff;
               maxy_in   = (qy_ff > maxy_ff) ? qy_ff : maxy_ff;
               vcount_in = vcount_ff + 1'b1;
               built_in  = 1'b0;
            end
         end
         OP_ADD_E: begin
            if (!e_full) begin
               ecount_in = ecount_ff + 1'b1;
               built_in  = 1'b0;
            end
         end
         OP_Q_START: begin
            lo_in = '0;
            hi_in = signed'(SW'(scount_ff)) - ONE_S;
         end
         OP_Q_PROBE: mid_in = mid_calc;
         OP_Q_CHECK: begin
            if (qx_ff < b0) begin
               hi_in = signed'(SW'(mid_ff)) - ONE_S;
            end else if (qx_ff > b1) begin
               lo_in = signed'(SW'(mid_ff)) + ONE_S;
            end else begin
               q_top_in    = sed_top;
               q_bot_in    = sed_bot;
               eval_bot_in = 1'b0;
            end
         end
         OP_E_V0: eb_in = ed_b;
         OP_E_V1: begin
            ax_in = vx_s;
            ay_in = vy_s;
         end
         OP_E_V2: begin
            // Fold the edge direction so that the run is never negative
            if (dxe[CW]) begin
               d_in = -OW'(dxe);
               t_in = -OW'(txe);
            end else begin
               d_in = OW'(dxe);
               t_in = OW'(txe);
            end
            dy_in = OW'(dye);
            ey_in = OW'(eye);
         end
         OP_E_SIGN: eval_bot_in = 1'b1;
         OP_B_INIT: begin
            scount_in     = '0;
            prev_valid_in = 1'b0;
            built_in      = 1'b0;
            e_in          = '0;
         end
         OP_B_PASS: begin
            idx_in        = '0;
            pend_in       = 1'b0;
            best_valid_in = 1'b0;
         end
         OP_B_SCAN: begin
            // Find the smallest x above the last unique value
            pend_in = (idx_ff != vcount_ff);
            if (idx_ff != vcount_ff) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff && (!prev_valid_ff || (vx_s > prev_ff)) &&
                (!best_valid_ff || (vx_s < best_ff))) begin
               best_in       = vx_s;
               best_valid_in = 1'b1;
            end
         end
         OP_B_PASS_END: begin
            if (best_valid_ff) begin
               if (prev_valid_ff) begin
                  scount_in = scount_ff + 1'b1;
               end
               prev_in       = best_ff;
               prev_valid_in = 1'b1;
            end
         end
         OP_B_E_RD: begin
            if (e_ff == ecount_ff) begin
               built_in = 1'b1;
            end
         end
         OP_B_E_A: begin
            eb_in = ed_b;
            if (status.edge_bad) begin
               e_in = e_ff + 1'b1;
            end
         end
         OP_B_E_B: begin
            ax_in = vx_s;
            ay_in = vy_s;
         end
         OP_B_E_C: begin
            left_in  = (ax_ff < vx_s) ? ax_ff : vx_s;
            right_in = (ax_ff > vx_s) ? ax_ff : vx_s;
            ymax_in  = (ay_ff > vy_s) ? ay_ff : vy_s;
            ymin_in  = (ay_ff < vy_s) ? ay_ff : vy_s;
            i_in     = '0;
         end
         OP_B_S_RD: begin
            if (i_ff == scount_ff) begin
               e_in = e_ff + 1'b1;
            end
         end
         OP_B_S_CHK: begin
            cur_top_in = sed_top;
            if (!spans || !sed_ht) begin
               i_in = i_ff + 1'b1;
            end
         end
         OP_B_T_A: eb_in = ed_b;
         OP_B_T_B: ay_in = vy_s;
         OP_B_T_C: i_in = i_ff + 1'b1;
         default: cmd_in = cmd_ff;
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in  = cmd.reply;
      rsp_inside_in = cmd.reply_inside;
      rsp_status_in = cmd.reply_status;
      if ((op == OP_ADD_V) && !v_full) begin
         rsp_index_in = VIDX_W'(vcount_ff);
      end else if ((op == OP_ADD_E) && !e_full) begin
         rsp_index_in = VIDX_W'(ecount_ff);
      end else begin
         rsp_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= '0;
         ecount_ff    <= '0;
         scount_ff    <= '0;
         minx_ff      <= BIG;
         miny_ff      <= BIG;
         maxx_ff      <= SMALL;
         maxy_ff      <= SMALL;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         ecount_ff    <= ecount_in;
         scount_ff    <= scount_in;
         minx_ff      <= minx_in;
         miny_ff      <= miny_in;
         maxx_ff      <= maxx_in;
         maxy_ff      <= maxy_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;  qx_ff <= qx_in;  qy_ff <= qy_in;  fv_ff <= fv_in;  sv_ff <= sv_in;
      idx_ff <= idx_in;  pend_ff <= pend_in;
      prev_ff <= prev_in;  prev_valid_ff <= prev_valid_in;
      best_ff <= best_in;  best_valid_ff <= best_valid_in;
      e_ff <= e_in;  eb_ff <= eb_in;  ax_ff <= ax_in;  ay_ff <= ay_in;
      left_ff <= left_in;  right_ff <= right_in;  ymax_ff <= ymax_in;  ymin_ff <= ymin_in;
      i_ff <= i_in;  cur_top_ff <= cur_top_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;  mid_ff <= mid_in;
      q_top_ff <= q_top_in;  q_bot_ff <= q_bot_in;  eval_bot_ff <= eval_bot_in;
      t_ff <= t_in;  d_ff <= d_in;  dy_ff <= dy_in;  ey_ff <= ey_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Status toward the controller
   always_comb begin
      status.cmd          = cmd_ff;
      status.v_full       = v_full;
      status.e_full       = e_full;
      status.built        = built_ff;
      status.in_box       = (qx_ff >= minx_ff) && (qx_ff <= maxx_ff) &&
                            (qy_ff >= miny_ff) && (qy_ff <= maxy_ff);
      status.search_empty = (lo_ff > hi_ff);
      status.x_below      = (qx_ff < b0);
      status.x_above      = (qx_ff > b1);
      status.has_both     = sed_ht && sed_hb;
      status.scan_done    = (idx_ff == vcount_ff) && !pend_ff;
      status.best_valid   = best_valid_ff;
      status.edges_done   = (e_ff == ecount_ff);
      status.edge_bad     = (CMPW'(ed_a) >= CMPW'(vcount_ff)) ||
                            (CMPW'(ed_b) >= CMPW'(vcount_ff));
      status.slabs_done   = (i_ff == scount_ff);
      status.spans        = spans;
      status.has_top      = sed_ht;
      status.top_above    = top_above;
      status.top_below    = top_below;
      status.mac_busy     = mac_busy;
      status.sign_ok      = eval_bot_ff ? (acc_neg || acc_zero) : !acc_neg;
      status.eval_bottom  = eval_bot_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_new_index  = rsp_index_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// File: hdl/cps_ctrl.sv
// Controller state machine: sequences add, build and query transactions.
`timescale 1ns / 1ps

module cps_ctrl import cps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = S_DECODE;
         S_DECODE: begin
            case (status.cmd)
               CMD_ADD_VERTEX: state_in = S_ADD_V;
               CMD_ADD_EDGE:   state_in = S_ADD_E;
               CMD_BUILD:      state_in = S_B_INIT;
               default:        state_in = S_Q_START;
            endcase
         end
         S_ADD_V, S_ADD_E: state_in = S_IDLE;
         S_Q_START: state_in = (status.built && status.in_box) ? S_Q_PROBE : S_IDLE;
         S_Q_PROBE: state_in = status.search_empty ? S_IDLE : S_Q_CHECK;
         S_Q_CHECK: begin
            if (status.x_below || status.x_above) state_in = S_Q_PROBE;
            else if (status.has_both)             state_in = S_E_EDGE;
            else                                  state_in = S_IDLE;
         end
         S_E_EDGE:  state_in = S_E_V0;
         S_E_V0:    state_in = S_E_V1;
         S_E_V1:    state_in = S_E_V2;
         S_E_V2:    state_in = S_E_MUL1;
         S_E_MUL1:  state_in = S_E_WAIT1;
         S_E_WAIT1: if (!status.mac_busy) state_in = S_E_MUL2;
         S_E_MUL2:  state_in = S_E_WAIT2;
         S_E_WAIT2: if (!status.mac_busy) state_in = S_E_SIGN;
         S_E_SIGN: begin
            state_in = (status.sign_ok && !status.eval_bottom) ? S_E_EDGE : S_IDLE;
         end
         S_B_INIT: state_in = S_B_PASS;
         S_B_PASS: state_in = S_B_SCAN;
         S_B_SCAN: if (status.scan_done) state_in = S_B_PASS_END;
         S_B_PASS_END: state_in = status.best_valid ? S_B_PASS : S_B_E_RD;
         S_B_E_RD: state_in = status.edges_done ? S_IDLE : S_B_E_A;
         S_B_E_A:  state_in = status.edge_bad ? S_B_E_RD : S_B_E_B;
         S_B_E_B:  state_in = S_B_E_C;
         S_B_E_C:  state_in = S_B_S_RD;
         S_B_S_RD: state_in = status.slabs_done ? S_B_E_RD : S_B_S_CHK;
         S_B_S_CHK: begin
            state_in = (status.spans && status.has_top) ? S_B_T_A : S_B_S_RD;
         end
         S_B_T_A: state_in = S_B_T_B;
         S_B_T_B: state_in = S_B_T_C;
         S_B_T_C: begin
            state_in = (status.top_above || status.top_below) ? S_B_S_RD : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs: datapath operation and the result to post
   always_comb begin
      cmd.op           = OP_NONE;
      cmd.reply        = 1'b0;
      cmd.reply_inside = 1'b0;
      cmd.reply_status = ST_OK;
      case (state_ff)
         S_IDLE:   if (start) cmd.op = OP_ACCEPT;
         S_DECODE: cmd.op = OP_NONE;
         S_ADD_V: begin
            cmd.op           = OP_ADD_V;
            cmd.reply        = 1'b1;
            cmd.reply_status = status.v_full ? ST_FULL : ST_OK;
         end
         S_ADD_E: begin
            cmd.op           = OP_ADD_E;
            cmd.reply        = 1'b1;
            cmd.reply_status = status.e_full ? ST_FULL : ST_OK;
         end
         S_Q_START: begin
            cmd.op           = OP_Q_START;
            cmd.reply        = !(status.built && status.in_box);
            cmd.reply_status = status.built ? ST_OK : ST_NOT_BUILT;
         end
         S_Q_PROBE: begin
            cmd.op    = OP_Q_PROBE;
            cmd.reply = status.search_empty;
         end
         S_Q_CHECK: begin
            cmd.op    = OP_Q_CHECK;
            cmd.reply = !status.x_below && !status.x_above && !status.has_both;
         end
         S_E_EDGE:  cmd.op = OP_E_EDGE;
         S_E_V0:    cmd.op = OP_E_V0;
         S_E_V1:    cmd.op = OP_E_V1;
         S_E_V2:    cmd.op = OP_E_V2;
         S_E_MUL1:  cmd.op = OP_E_MUL1;
         S_E_MUL2:  cmd.op = OP_E_MUL2;
         S_E_WAIT1, S_E_WAIT2: cmd.op = OP_E_WAIT;
         S_E_SIGN: begin
            cmd.op           = OP_E_SIGN;
            cmd.reply        = !(status.sign_ok && !status.eval_bottom);
            cmd.reply_inside = status.sign_ok;
         end
         S_B_INIT:     cmd.op = OP_B_INIT;
         S_B_PASS:     cmd.op = OP_B_PASS;
         S_B_SCAN:     cmd.op = OP_B_SCAN;
         S_B_PASS_END: cmd.op = OP_B_PASS_END;
         S_B_E_RD: begin
            cmd.op    = OP_B_E_RD;
            cmd.reply = status.edges_done;
         end
         S_B_E_A:   cmd.op = OP_B_E_A;
         S_B_E_B:   cmd.op = OP_B_E_B;
         S_B_E_C:   cmd.op = OP_B_E_C;
         S_B_S_RD:  cmd.op = OP_B_S_RD;
         S_B_S_CHK: cmd.op = OP_B_S_CHK;
         S_B_T_A:   cmd.op = OP_B_T_A;
         S_B_T_B:   cmd.op = OP_B_T_B;
         S_B_T_C: begin
            cmd.op           = OP_B_T_C;
            cmd.reply        = !(status.top_above || status.top_below);
            cmd.reply_status = ST_CONFLICT;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: hdl/convex_polygon_slab_point_test_unit.sv
// Top level: convex polygon slab point test unit, controller plus datapath.
// Add vertex or edge, and a query before build or outside the box, end without a search;
// other queries binary-search the slabs and, if the slab has both edges, test the top edge
// and, if it passes, the bottom one by products on the bit-serial multiply-accumulate.
// Build runs one x-sort scan over the vertex RAM read port per unique x plus a final one,
// then visits each edge and each edge and slab pair until an ordering conflict, if any.
// One transaction at a time; busy stays high until the result, on rsp_ ports for one cycle.
// Reset (synchronous): empties all tables, clears the built flag; no clearing pass is needed.
`timescale 1ns / 1ps

module convex_polygon_slab_point_test_unit import cps_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 64,
   parameter int COORD_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic [VIDX_W-1:0]             req_first_vertex,
   input  logic [VIDX_W-1:0]             req_second_vertex,
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   output logic [VIDX_W-1:0]             rsp_new_index,
   output logic [1:0]                    rsp_status
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // Sequencer
   cps_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .status(dp_status), .cmd(ctrl_cmd)
   );

   // Stores and arithmetic
   cps_datapath #(
      .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .COORD_WIDTH(COORD_WIDTH)
   ) u_datapath (
      .clock(clock), .reset(reset), .cmd(ctrl_cmd), .status(dp_status),
      .req_cmd(req_cmd), .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_first_vertex(req_first_vertex), .req_second_vertex(req_second_vertex),
      .rsp_valid(rsp_valid), .rsp_inside_res(rsp_inside_res),
      .rsp_new_index(rsp_new_index), .rsp_status(rsp_status)
   );

endmodule

// File: tb/sv/tb_convex_polygon_slab_point_test_unit.sv
// Testbench for the convex polygon slab point test unit: directed table, then random polygon.
`timescale 1ns / 1ps

module tb_convex_polygon_slab_point_test_unit import cps_pkg::*; ();

   localparam int  Q          = 65536;      // one unit in Q16.16
   localparam int  NSEG       = 23;         // segments per chain of the random polygon
   localparam int  IDLE_LIMIT = 200000;
   localparam longint CMAX    = 64'sd2147483647;
   localparam longint CMIN    = -64'sd2147483648;

   typedef struct {
      cmd_type            cmd;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [5:0]         fv;
      logic [5:0]         sv;
      bit                 typed;
      logic               ins;
      logic [5:0]         idx;
      status_type         st;
   } row_type;

   typedef struct {
      logic       ins;
      logic [5:0] idx;
      status_type st;
   } answer_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_cmd;
   logic signed [31:0]  req_coord_x;
   logic signed [31:0]  req_coord_y;
   logic [5:0]          req_first_vertex;
   logic [5:0]          req_second_vertex;
   logic                rsp_valid;
   logic                rsp_inside_res;
   logic [5:0]          rsp_new_index;
   logic [1:0]          rsp_status;

   convex_polygon_slab_point_test_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_first_vertex(req_first_vertex), .req_second_vertex(req_second_vertex),
      .rsp_valid(rsp_valid), .rsp_inside_res(rsp_inside_res),
      .rsp_new_index(rsp_new_index), .rsp_status(rsp_status)
   );

   // Mirror of the polygon tables
   longint      vtx_x[64];
   longint      vtx_y[64];
   int unsigned edge_a[64];
   int unsigned edge_b[64];
   longint      slab_lo[64];
   longint      slab_hi[64];
   int unsigned slab_top[64];
   int unsigned slab_bot[64];
   bit          slab_has_top[64];
   bit          slab_has_bot[64];
   int          n_vtx, n_edge, n_slab;
   longint      box_min_x, box_min_y, box_max_x, box_max_y;
   bit          slabs_built;

   answer_type  pending_answers[$];
   row_type     directed_rows[$];
   int          mismatches;
   int          idle_cycles;
   int          burst_left;

   // Random polygon layout
   int          poly_x[NSEG+1];
   int          poly_h[NSEG+1];
   int          poly_base;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sign of a*b - c*d, exact
   function automatic int product_sign(longint a, longint b, longint c, longint d);
      logic signed [127:0] wa, wb, wc, wd, p, q;
      wa = a; wb = b; wc = c; wd = d;
      p = wa * wb;
      q = wc * wd;
      return (p < q) ? -1 : ((p > q) ? 1 : 0);
   endfunction

   // Sign of edge height at x minus y
   function automatic int edge_height_sign(int unsigned e, longint x, longint y);
      longint t, d, dy, ey;
      t  = x - vtx_x[edge_a[e]];
      d  = vtx_x[edge_b[e]] - vtx_x[edge_a[e]];
      dy = vtx_y[edge_b[e]] - vtx_y[edge_a[e]];
      ey = y - vtx_y[edge_a[e]];
      if (d < 0) begin
         t = -t;
         d = -d;
      end
      return product_sign(t, dy, ey, d);
   endfunction

   // Sort x values, form slabs, assign top and bottom edges; 0 on ordering conflict
   function automatic bit build_slabs();
      longint xs[64];
      longint v, left, right, ymax, ymin, tmax, tmin;
      int j;
      int unsigned a, b, ta, tb;
      for (int i = 0; i < n_vtx; i++) begin
         v = vtx_x[i];
         j = i;
         while (j > 0 && xs[j-1] > v) begin
            xs[j] = xs[j-1];
            j--;
         end
         xs[j] = v;
      end
      n_slab = 0;
      for (int i = 1; i < n_vtx; i++) begin
         if (xs[i-1] != xs[i]) begin
            slab_lo[n_slab] = xs[i-1];
            slab_hi[n_slab] = xs[i];
            slab_top[n_slab] = 0;
            slab_bot[n_slab] = 0;
            slab_has_top[n_slab] = 1'b0;
            slab_has_bot[n_slab] = 1'b0;
            n_slab++;
         end
      end
      for (int e = 0; e < n_edge; e++) begin
         a = edge_a[e];
         b = edge_b[e];
         if (a >= n_vtx || b >= n_vtx) continue;
         left  = (vtx_x[a] < vtx_x[b]) ? vtx_x[a] : vtx_x[b];
         right = (vtx_x[a] > vtx_x[b]) ? vtx_x[a] : vtx_x[b];
         ymax  = (vtx_y[a] > vtx_y[b]) ? vtx_y[a] : vtx_y[b];
         ymin  = (vtx_y[a] < vtx_y[b]) ? vtx_y[a] : vtx_y[b];
         for (int s = 0; s < n_slab; s++) begin
            if (!(left <= slab_lo[s] && right >= slab_hi[s])) continue;
            if (!slab_has_top[s]) begin
               slab_top[s] = e;
               slab_has_top[s] = 1'b1;
               continue;
            end
            ta = edge_a[slab_top[s]];
            tb = edge_b[slab_top[s]];
            tmax = (vtx_y[ta] > vtx_y[tb]) ? vtx_y[ta] : vtx_y[tb];
            tmin = (vtx_y[ta] < vtx_y[tb]) ? vtx_y[ta] : vtx_y[tb];
            if (tmax >= ymax && tmin >= ymin) begin
               slab_bot[s] = e;
            end else if (tmax <= ymax && tmin <= ymin) begin
               slab_bot[s] = slab_top[s];
               slab_top[s] = e;
            end else begin
               return 1'b0;
            end
            slab_has_bot[s] = 1'b1;
         end
      end
      return 1'b1;
   endfunction

   // Apply one transaction to the mirror and return its answer
   function automatic answer_type polygon_answer(row_type r);
      answer_type ans;
      longint x, y;
      int lo, hi, mid;
      ans = '{1'b0, 6'd0, ST_OK};
      x = r.x;
      y = r.y;
      case (r.cmd)
         CMD_ADD_VERTEX: begin
            if (n_vtx >= 64) begin
               ans.st = ST_FULL;
            end else begin
               vtx_x[n_vtx] = x;
               vtx_y[n_vtx] = y;
               if (x < box_min_x) box_min_x = x;
               if (y < box_min_y) box_min_y = y;
               if (x > box_max_x) box_max_x = x;
               if (y > box_max_y) box_max_y = y;
               ans.idx = n_vtx[5:0];
               n_vtx++;
               slabs_built = 1'b0;
            end
         end
         CMD_ADD_EDGE: begin
            if (n_edge >= 64) begin
               ans.st = ST_FULL;
            end else begin
               edge_a[n_edge] = r.fv;
               edge_b[n_edge] = r.sv;
               ans.idx = n_edge[5:0];
               n_edge++;
               slabs_built = 1'b0;
            end
         end
         CMD_BUILD: begin
            slabs_built = build_slabs();
            if (!slabs_built) ans.st = ST_CONFLICT;
         end
         default: begin
            if (!slabs_built) begin
               ans.st = ST_NOT_BUILT;
            end else if (x >= box_min_x && x <= box_max_x &&
                         y >= box_min_y && y <= box_max_y) begin
               lo = 0;
               hi = n_slab - 1;
               while (lo <= hi) begin
                  mid = (lo + hi) / 2;
                  if (x < slab_lo[mid]) begin
                     hi = mid - 1;
                  end else if (x > slab_hi[mid]) begin
                     lo = mid + 1;
                  end else begin
                     if (slab_has_top[mid] && slab_has_bot[mid] &&
                         edge_height_sign(slab_top[mid], x, y) >= 0 &&
                         edge_height_sign(slab_bot[mid], x, y) <= 0)
                        ans.ins = 1'b1;
                     break;
                  end
               end
            end
         end
      endcase
      return ans;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: %s got %0d, expected %0d", $time, field, got, want);
      mismatches++;
   endtask

   // Append one row to the directed table
   task automatic table_row(row_type r);
      directed_rows = {directed_rows, r};
   endtask

   // Drive one transaction from a falling edge; hold it until the block is no longer busy
   task automatic send(row_type r);
      answer_type ans;
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_cmd           = r.cmd;
      req_coord_x       = r.x;
      req_coord_y       = r.y;
      req_first_vertex  = r.fv;
      req_second_vertex = r.sv;
      start             = 1'b1;
      do @(posedge clock); while (busy);
      ans = polygon_answer(r);
      if (r.typed) ans = '{r.ins, r.idx, r.st};
      pending_answers = {pending_answers, ans};
      @(negedge clock);
   endtask

   function automatic row_type mk(cmd_type c, int x, int y, int fv, int sv);
      row_type r;
      r = '{c, x, y, fv[5:0], sv[5:0], 1'b0, 1'b0, 6'd0, ST_OK};
      return r;
   endfunction

   function automatic row_type mk_typed(cmd_type c, int x, int y, int fv, int sv,
                                        logic ins, int idx, status_type st);
      row_type r;
      r = '{c, x, y, fv[5:0], sv[5:0], 1'b1, ins, idx[5:0], st};
      return r;
   endfunction

   function automatic row_type rnd_query();
      int pick, k;
      row_type r;
      r = mk(CMD_QUERY, $urandom, $urandom, $urandom, $urandom);
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, NSEG);
      if (pick < 6) begin
         r.x = poly_x[0] - 5*Q + $urandom_range(0, poly_x[NSEG] - poly_x[0] + 10*Q);
         r.y = -210*Q + $urandom_range(0, 420*Q);
      end else if (pick < 8) begin
         r.x = poly_x[k];
         r.y = ($urandom_range(0, 1) == 1) ? poly_h[k] : -poly_h[k];
         r.y = r.y + $urandom_range(0, 2) - 1;
      end
      return r;
   endfunction

   // Check each result against the oldest expectation; watch for a stall
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("rsp_valid", 1, 0);
            end else begin
               answer_type want;
               want = pending_answers.pop_front();
               if (rsp_inside_res !== want.ins)
                  report_mismatch("inside_res", rsp_inside_res, want.ins);
               if (rsp_new_index !== want.idx)
                  report_mismatch("new_index", rsp_new_index, want.idx);
               if (rsp_status !== want.st)
                  report_mismatch("status", rsp_status, want.st);
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int vbase, k;
      mismatches = 0;
      burst_left = 0;
      n_vtx = 0; n_edge = 0; n_slab = 0;
      box_min_x = CMAX; box_min_y = CMAX;
      box_max_x = CMIN; box_max_y = CMIN;
      slabs_built = 1'b0;
      start = 1'b0;
      req_cmd = CMD_ADD_VERTEX;
      req_coord_x = '0;
      req_coord_y = '0;
      req_first_vertex = '0;
      req_second_vertex = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty tables, extremes, a square, bad endpoint, an extra edge across the square
      table_row(mk_typed(CMD_QUERY, 0, 0, 0, 0, 1'b0, 0, ST_NOT_BUILT));
      table_row(mk_typed(CMD_BUILD, 0, 0, 0, 0, 1'b0, 0, ST_OK));
      table_row(mk_typed(CMD_QUERY, 0, 0, 63, 63, 1'b0, 0, ST_OK));
      table_row(mk_typed(CMD_ADD_VERTEX, 32'h8000_0000, 32'h8000_0000,
                         0, 0, 1'b0, 0, ST_OK));
      table_row(mk_typed(CMD_ADD_VERTEX, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         63, 63, 1'b0, 1, ST_OK));
      table_row(mk_typed(CMD_ADD_VERTEX, -100*Q, -10*Q, 0, 0, 1'b0, 2, ST_OK));
      table_row(mk_typed(CMD_ADD_VERTEX, -100*Q, 10*Q, 0, 0, 1'b0, 3, ST_OK));
      table_row(mk_typed(CMD_ADD_VERTEX, -80*Q, 10*Q, 0, 0, 1'b0, 4, ST_OK));
      table_row(mk_typed(CMD_ADD_VERTEX, -80*Q, -10*Q, 0, 0, 1'b0, 5, ST_OK));
      table_row(mk_typed(CMD_ADD_EDGE, 0, 0, 3, 4, 1'b0, 0, ST_OK));
      table_row(mk_typed(CMD_ADD_EDGE, 0, 0, 2, 5, 1'b0, 1, ST_OK));
      table_row(mk_typed(CMD_ADD_EDGE, 0, 0, 63, 63, 1'b0, 2, ST_OK));
      table_row(mk(CMD_BUILD, 0, 0, 0, 0));
      table_row(mk(CMD_QUERY, -90*Q, 0, 0, 0));
      table_row(mk(CMD_QUERY, -90*Q, 10*Q, 0, 0));
      table_row(mk(CMD_QUERY, -90*Q, 10*Q + 1, 0, 0));
      table_row(mk(CMD_QUERY, -100*Q, -10*Q, 0, 0));
      table_row(mk(CMD_QUERY, 0, 0, 0, 0));
      table_row(mk(CMD_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 63, 0));
      table_row(mk(CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 0, 63));
      table_row(mk_typed(CMD_ADD_VERTEX, -100*Q, 0, 0, 0, 1'b0, 6, ST_OK));
      table_row(mk_typed(CMD_ADD_VERTEX, -80*Q, 0, 0, 0, 1'b0, 7, ST_OK));
      table_row(mk_typed(CMD_QUERY, -90*Q, 0, 0, 0, 1'b0, 0, ST_NOT_BUILT));
      table_row(mk_typed(CMD_ADD_EDGE, 0, 0, 6, 7, 1'b0, 3, ST_OK));
      table_row(mk(CMD_BUILD, 0, 0, 0, 0));
      table_row(mk(CMD_QUERY, -90*Q, -5*Q, 0, 0));
      table_row(mk(CMD_QUERY, -90*Q, 5*Q, 0, 0));
      foreach (directed_rows[i]) send(directed_rows[i]);

      // Random polygon, symmetric about y = 0, clear of the square in x
      for (int i = 0; i <= NSEG; i++) begin
         poly_x[i] = 10*Q + i*40*Q + $urandom_range(0, 20*Q);
         poly_h[i] = (i == 0 || i == NSEG) ? 0 : $urandom_range(10*Q, 200*Q);
      end
      poly_base = n_vtx;
      send(mk(CMD_ADD_VERTEX, poly_x[0], 0, $urandom, $urandom));
      send(mk(CMD_ADD_VERTEX, poly_x[NSEG], 0, $urandom, $urandom));
      for (int i = 1; i < NSEG; i++) begin
         send(mk(CMD_ADD_VERTEX, poly_x[i], poly_h[i], $urandom, $urandom));
         if ($urandom_range(0, 3) == 0) send(rnd_query());
         send(mk(CMD_ADD_VERTEX, poly_x[i], -poly_h[i], $urandom, $urandom));
      end
      send(mk(CMD_BUILD, 0, 0, 0, 0));
      repeat (10) send(rnd_query());
      // Upper and lower chains; vertex k of a chain maps to a table index
      for (int i = 0; i < NSEG; i++) begin
         for (int lower = 0; lower < 2; lower++) begin
            int a, b;
            a = (i == 0) ? poly_base : poly_base + 2*i + lower;
            b = (i + 1 == NSEG) ? poly_base + 1 : poly_base + 2*(i+1) + lower;
            send(mk(CMD_ADD_EDGE, $urandom, $urandom, a, b));
            if ($urandom_range(0, 4) == 0) send(rnd_query());
         end
         if (i == NSEG/2) send(mk(CMD_BUILD, 0, 0, 0, 0));
      end
      send(mk(CMD_BUILD, 0, 0, 0, 0));

      // Hold off until every answer is back
      start = 1'b0;
      burst_left = 0;
      while (pending_answers.size() != 0) @(negedge clock);

      for (int i = 0; i < 300; i++) begin
         if ($urandom_range(0, 99) == 0) send(mk(CMD_BUILD, 0, 0, $urandom, $urandom));
         else send(rnd_query());
      end

      // Tail: crossing edge forces a conflict, then fill both tables past full
      vbase = n_vtx;
      send(mk(CMD_ADD_VERTEX, poly_x[0], 1000*Q, 0, 0));
      send(mk(CMD_ADD_VERTEX, poly_x[NSEG], -1000*Q, 0, 0));
      send(mk(CMD_ADD_EDGE, 0, 0, vbase, vbase + 1));
      send(mk(CMD_BUILD, 0, 0, 0, 0));
      send(rnd_query());
      k = 66 - n_vtx;
      repeat (k) send(mk(CMD_ADD_VERTEX, $urandom, $urandom, $urandom, $urandom));
      k = 66 - n_edge;
      repeat (k) send(mk(CMD_ADD_EDGE, $urandom, $urandom, $urandom, $urandom));
      send(mk(CMD_BUILD, 0, 0, 0, 0));
      repeat (5) send(rnd_query());

      // Drain and let the block settle
      start = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
